### hw/rtl/pcc_pkg.sv
package pcc_pkg;

  // item command codes
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // widths fixed by the item and register formats
  localparam int COLOR_W   = 24;
  localparam int INDEX_W   = 8;
  localparam int ACC_W     = 14;
  localparam int RATE_W    = 15;
  localparam int SETUP_W   = 33;
  localparam int CFG_IDX_W = 3;

  // number of ranges that own a setup register
  localparam int SETUP_REGS = 4;

  // setup register field positions
  localparam int SETUP_EN_BIT  = 0;
  localparam int SETUP_REV_BIT = 1;
  localparam int SETUP_LOW_LSB = 2;
  localparam int SETUP_HIGH_LSB = 10;
  localparam int SETUP_RATE_LSB = 18;

  // one full step of the accumulator, also the rate ceiling
  localparam logic [RATE_W-1:0] STEP_ONE = 15'h4000;

  typedef struct packed {
    cmd_e                 cmd;
    logic [INDEX_W-1:0]   entry_index;
    logic [COLOR_W-1:0]   entry_color;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0]   read_color;
    logic                 palette_changed;
  } result_t;

  // accumulator update handed back to the sequencer
  typedef struct packed {
    logic [ACC_W-1:0]     acc;
    logic                 stepped;
  } step_t;

endpackage

### hw/rtl/palette_range_color_cycler_core.sv
// Palette store with color-cycling ranges. An item is taken when start_i is
// high and busy_o is low; its result shows on result_o for one cycle with
// done_o high and cannot be held off. A write finishes with busy_o kept low;
// a read goes through ST_RD_WAIT. A tick walks the ranges one per cycle while
// no rotation holds it and, for each range that steps with a valid low..high
// span, rotates the span through ST_ROT_START, ST_ROT_KEEP, ST_ROT_MOVE and
// ST_ROT_LAST, moving one entry per cycle through the palette memory's
// separate read and write ports. Setup registers are written at any edge with
// cfg_we_i high; the user must write them only while idle, as the block leaves it to the user.
module palette_range_color_cycler_core import pcc_pkg::*; #(
  parameter int RANGE_COUNT   = 4,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  item_t                item_i,
  output logic                 busy_o,
  output logic                 done_o,
  output result_t              result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SETUP_W-1:0]   cfg_wdata_i
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int RW = (RANGE_COUNT > 1) ? $clog2(RANGE_COUNT) : 1;
  localparam logic [RW-1:0]      LAST_RANGE = RW'(RANGE_COUNT - 1);
  localparam logic [INDEX_W:0]   DEPTH_LIM  = (INDEX_W + 1)'(PALETTE_DEPTH);
  localparam logic [CFG_IDX_W:0] RANGE_LIM  = (CFG_IDX_W + 1)'(RANGE_COUNT);
  localparam logic [CFG_IDX_W:0] SETUP_LIM  = (CFG_IDX_W + 1)'(SETUP_REGS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_TICK,
    ST_ROT_START,
    ST_ROT_KEEP,
    ST_ROT_MOVE,
    ST_ROT_LAST
  } state_e;

  state_e               state_q;
  logic [RW-1:0]        ridx_q;
  logic                 changed_q;
  logic                 done_q;
  result_t              result_q;
  logic                 rd_ok_q;
  logic [COLOR_W-1:0]   keep_q;
  logic [AW-1:0]        rd_addr_q;
  logic [ACC_W-1:0]     acc_q [RANGE_COUNT];
  logic [SETUP_W-1:0]   setup_q [RANGE_COUNT];

  logic [COLOR_W-1:0]   mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0]   rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [COLOR_W-1:0]   mem_wdata;
  logic [AW-1:0]        mem_raddr;

  logic [SETUP_W-1:0]   cur_setup;
  logic                 cur_en;
  logic                 cur_rev;
  logic [INDEX_W-1:0]   low8;
  logic [INDEX_W-1:0]   high8;
  logic                 range_ok;
  logic [AW-1:0]        low_a;
  logic [AW-1:0]        high_a;
  logic [AW-1:0]        keep_addr;
  logic [AW-1:0]        first_addr;
  logic [AW-1:0]        end_addr;
  logic [AW-1:0]        next_addr;
  logic [AW-1:0]        move_addr;
  logic                 idx_ok;
  logic                 last_range;
  logic                 tick_step;
  step_t                step;

  // setup registers; ranges without a register stay disabled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RANGE_COUNT; i++) begin
        setup_q[i] <= '0;
      end
    end else if (cfg_we_i && ({1'b0, cfg_index_i} < RANGE_LIM) &&
                 ({1'b0, cfg_index_i} < SETUP_LIM)) begin
      setup_q[RW'(cfg_index_i)] <= cfg_wdata_i;
    end
  end

  // fields of the range under work
  assign cur_setup = setup_q[ridx_q];
  assign cur_en    = cur_setup[SETUP_EN_BIT];
  assign cur_rev   = cur_setup[SETUP_REV_BIT];
  assign low8      = cur_setup[SETUP_LOW_LSB +: INDEX_W];
  assign high8     = cur_setup[SETUP_HIGH_LSB +: INDEX_W];
  assign range_ok  = (low8 < high8) && ({1'b0, high8} < DEPTH_LIM);
  assign low_a     = low8[AW-1:0];
  assign high_a    = high8[AW-1:0];

  // rotation addresses: forward streams high-1 down to low, reverse low+1 up to high
  assign keep_addr  = cur_rev ? low_a : high_a;
  assign first_addr = cur_rev ? (low_a + AW'(1)) : (high_a - AW'(1));
  assign end_addr   = cur_rev ? high_a : low_a;
  assign next_addr  = cur_rev ? (rd_addr_q + AW'(1)) : (rd_addr_q - AW'(1));
  assign move_addr  = cur_rev ? (rd_addr_q - AW'(1)) : (rd_addr_q + AW'(1));

  assign idx_ok     = ({1'b0, item_i.entry_index} < DEPTH_LIM);
  assign last_range = (ridx_q == LAST_RANGE);

  // shared accumulator step unit
  pcc_acc_step u_step (
    .acc_i  (acc_q[ridx_q]),
    .rate_i (cur_setup[SETUP_RATE_LSB +: RATE_W]),
    .step_o (step)
  );

  assign tick_step = cur_en && step.stepped;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    unique case (state_q)
      ST_IDLE: begin
        mem_raddr = item_i.entry_index[AW-1:0];
        if (start_i && (item_i.cmd == CMD_WRITE) && idx_ok) begin
          mem_we    = 1'b1;
          mem_waddr = item_i.entry_index[AW-1:0];
          mem_wdata = item_i.entry_color;
        end
      end
      ST_ROT_START: mem_raddr = keep_addr;
      ST_ROT_KEEP:  mem_raddr = first_addr;
      ST_ROT_MOVE: begin
        mem_raddr = next_addr;
        mem_we    = 1'b1;
        mem_waddr = move_addr;
        mem_wdata = rdata_q;
      end
      ST_ROT_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = end_addr;
        mem_wdata = keep_q;
      end
      ST_RD_WAIT, ST_TICK: mem_raddr = '0;
      default: mem_raddr = '0;
    endcase
  end

  // palette memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ridx_q    <= '0;
      changed_q <= 1'b0;
      done_q    <= 1'b0;
      result_q  <= '0;
      rd_ok_q   <= 1'b0;
      keep_q    <= '0;
      rd_addr_q <= '0;
      for (int i = 0; i < RANGE_COUNT; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            unique case (item_i.cmd)
              CMD_TICK: begin
                ridx_q    <= '0;
                changed_q <= 1'b0;
                state_q   <= ST_TICK;
              end
              CMD_READ: begin
                rd_ok_q <= idx_ok;
                state_q <= ST_RD_WAIT;
              end
              CMD_WRITE, CMD_NONE: begin
                done_q   <= 1'b1;
                result_q <= '0;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_RD_WAIT: begin
          done_q                   <= 1'b1;
          result_q.read_color      <= rd_ok_q ? rdata_q : '0;
          result_q.palette_changed <= 1'b0;
          state_q                  <= ST_IDLE;
        end
        ST_TICK: begin
          if (cur_en) begin
            acc_q[ridx_q] <= step.acc;
          end
          if (tick_step) begin
            changed_q <= 1'b1;
          end
          if (tick_step && range_ok) begin
            state_q <= ST_ROT_START;
          end else if (last_range) begin
            done_q                   <= 1'b1;
            result_q.read_color      <= '0;
            result_q.palette_changed <= changed_q | tick_step;
            state_q                  <= ST_IDLE;
          end else begin
            ridx_q <= ridx_q + RW'(1);
          end
        end
        ST_ROT_START: state_q <= ST_ROT_KEEP;
        ST_ROT_KEEP: begin
          keep_q    <= rdata_q;
          rd_addr_q <= first_addr;
          state_q   <= ST_ROT_MOVE;
        end
        ST_ROT_MOVE: begin
          if (rd_addr_q == end_addr) begin
            state_q <= ST_ROT_LAST;
          end else begin
            rd_addr_q <= next_addr;
          end
        end
        ST_ROT_LAST: begin
          if (last_range) begin
            done_q                   <= 1'b1;
            result_q.read_color      <= '0;
            result_q.palette_changed <= changed_q;
            state_q                  <= ST_IDLE;
          end else begin
            ridx_q  <= ridx_q + RW'(1);
            state_q <= ST_TICK;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // an accepted item either finishes next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted item neither busy nor done");

  // palette is written only on a write item or during a rotation
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE || state_q == ST_ROT_MOVE || state_q == ST_ROT_LAST))
    else $error("palette write outside write item or rotation");

  // rotation stream stays inside the range span
  a_rotate_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROT_MOVE) |-> (range_ok && low_a <= rd_addr_q && rd_addr_q <= high_a))
    else $error("rotation address left the range");

  // a tick result cannot carry read data
  a_tick_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.palette_changed) |-> (result_o.read_color == '0))
    else $error("changed flag with read data");

endmodule

### hw/rtl/pcc_acc_step.sv
module pcc_acc_step import pcc_pkg::*; (
  input  logic [ACC_W-1:0]  acc_i,
  input  logic [RATE_W-1:0] rate_i,
  output step_t             step_o
);

  logic [RATE_W-1:0] rate_lim;
  logic [RATE_W-1:0] sum;

  // clamp rate to one full step
  assign rate_lim = (rate_i > STEP_ONE) ? STEP_ONE : rate_i;

  // sum stays below 2 * 0x4000, so the top bit is the step flag
  assign sum = RATE_W'({1'b0, acc_i}) + rate_lim;

  // dropping the top bit takes 0x4000 off when it stepped
  assign step_o.acc     = sum[ACC_W-1:0];
  assign step_o.stepped = sum[ACC_W];

endmodule
